[rtl/lpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths, types and step-unit operation codes of the line rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_W         = 6;
    localparam int INDEX_W         = 12;
    localparam int COLOR_W         = 32;
    localparam int FRAME_WIDTH_DEF = 64;

    // Operations of the shared add/compare unit
    typedef enum logic [1:0] {
        OP_ABSDIFF,
        OP_STEP_UP,
        OP_STEP_DN
    } alu_op_t;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } line_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } pix_t;

endpackage

[rtl/lpr_step_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_step_alu
// Shared narrow add/compare unit: absolute difference for set-up, and one
// remainder step of the running quotient while walking the line.
// ----------------------------------------------------------------------------
module lpr_step_alu (
    input  lpr_pkg::alu_op_t               op,
    input  logic [lpr_pkg::COORD_W-1:0]    a,
    input  logic [lpr_pkg::COORD_W-1:0]    b,
    input  logic [lpr_pkg::COORD_W-1:0]    c,
    output logic [lpr_pkg::COORD_W-1:0]    res,
    output logic                           flag
);
    import lpr_pkg::*;

    localparam int EXT_W = COORD_W + 2;

    logic signed [EXT_W-1:0] sa;
    logic signed [EXT_W-1:0] sb;
    logic signed [EXT_W-1:0] sc;
    logic signed [EXT_W-1:0] sum;
    logic signed [EXT_W-1:0] diff;
    logic signed [EXT_W-1:0] mag;

    always_comb
    begin
        sa   = signed'({2'b00, a});
        sb   = signed'({2'b00, b});
        sc   = signed'({2'b00, c});
        sum  = '0;
        diff = '0;
        mag  = '0;
        res  = '0;
        flag = 1'b0;
        unique case (op)
            OP_ABSDIFF:
            begin
                // flag: a below b
                diff = sa - sb;
                flag = diff[EXT_W-1];
                mag  = flag ? -diff : diff;
                res  = mag[COORD_W-1:0];
            end
            OP_STEP_UP:
            begin
                // r + a, wrap once past d; flag: quotient rises
                sum  = sa + sb;
                diff = sum - sc;
                flag = !diff[EXT_W-1];
                res  = flag ? diff[COORD_W-1:0] : sum[COORD_W-1:0];
            end
            OP_STEP_DN:
            begin
                // r - a, borrow d once; flag: quotient falls
                diff = sa - sb;
                flag = diff[EXT_W-1];
                sum  = diff + sc;
                res  = flag ? sum[COORD_W-1:0] : diff[COORD_W-1:0];
            end
            default:
            begin
                res  = '0;
                flag = 1'b0;
            end
        endcase
    end

endmodule

[rtl/lpr_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_walker
// Sequencer: measures the spans with the shared unit, then walks the major
// axis one pixel per step, keeping quotient and remainder of the minor offset.
// ----------------------------------------------------------------------------
module lpr_walker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lpr_pkg::line_t      line,
    output logic                idle,
    output logic                pix_valid,
    output lpr_pkg::pix_t       pix,
    input  logic                pix_take
);
    import lpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DX,
        S_DY,
        S_CMP,
        S_RUN
    } state_t;

    state_t               state_reg, state_next;
    line_t                line_reg, line_next;
    logic [COORD_W-1:0]   span_x_reg, span_x_next;
    logic [COORD_W-1:0]   span_y_reg, span_y_next;
    logic                 neg_x_reg, neg_x_next;
    logic                 neg_y_reg, neg_y_next;
    logic                 x_major_reg, x_major_next;
    logic                 dn_reg, dn_next;
    logic [COORD_W-1:0]   t_reg, t_next;
    logic [COORD_W-1:0]   hi_reg, hi_next;
    logic [COORD_W-1:0]   q_reg, q_next;
    logic [COORD_W-1:0]   r_reg, r_next;
    logic [COORD_W-1:0]   major_span_reg, major_span_next;
    logic [COORD_W-1:0]   minor_span_reg, minor_span_next;
    logic [COORD_W-1:0]   minor_start_reg, minor_start_next;
    logic                 minor_neg_reg, minor_neg_next;

    alu_op_t              alu_op;
    logic [COORD_W-1:0]   alu_a;
    logic [COORD_W-1:0]   alu_b;
    logic [COORD_W-1:0]   alu_c;
    logic [COORD_W-1:0]   alu_res;
    logic                 alu_flag;
    logic [COORD_W-1:0]   minor_coord;
    logic                 at_last;

    lpr_step_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .c    (alu_c),
        .res  (alu_res),
        .flag (alu_flag)
    );

    assign idle        = (state_reg == S_IDLE);
    assign pix_valid   = (state_reg == S_RUN);
    assign at_last     = (t_reg == hi_reg);
    assign minor_coord = minor_neg_reg ? (minor_start_reg - q_reg)
                                       : (minor_start_reg + q_reg);
    assign pix.x       = x_major_reg ? t_reg : minor_coord;
    assign pix.y       = x_major_reg ? minor_coord : t_reg;
    assign pix.last    = at_last;

    always_comb
    begin
        state_next       = state_reg;
        line_next        = line_reg;
        span_x_next      = span_x_reg;
        span_y_next      = span_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        x_major_next     = x_major_reg;
        dn_next          = dn_reg;
        t_next           = t_reg;
        hi_next          = hi_reg;
        q_next           = q_reg;
        r_next           = r_reg;
        major_span_next  = major_span_reg;
        minor_span_next  = minor_span_reg;
        minor_start_next = minor_start_reg;
        minor_neg_next   = minor_neg_reg;
        alu_op           = OP_ABSDIFF;
        alu_a            = line_reg.x_end;
        alu_b            = line_reg.x_start;
        alu_c            = major_span_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    line_next  = line;
                    state_next = S_DX;
                end
            end
            S_DX:
            begin
                span_x_next = alu_res;
                neg_x_next  = alu_flag;
                state_next  = S_DY;
            end
            S_DY:
            begin
                alu_a       = line_reg.y_end;
                alu_b       = line_reg.y_start;
                span_y_next = alu_res;
                neg_y_next  = alu_flag;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                // x span below y span selects y-major; ties stay x-major
                alu_a        = span_x_reg;
                alu_b        = span_y_reg;
                x_major_next = !alu_flag;
                r_next       = '0;
                if (!alu_flag)
                begin
                    major_span_next  = span_x_reg;
                    minor_span_next  = span_y_reg;
                    minor_start_next = line_reg.y_start;
                    minor_neg_next   = neg_y_reg;
                    dn_next          = neg_x_reg;
                    if (neg_x_reg)
                    begin
                        t_next  = line_reg.x_end;
                        hi_next = line_reg.x_start;
                        q_next  = span_y_reg;
                    end
                    else
                    begin
                        t_next  = line_reg.x_start;
                        hi_next = line_reg.x_end;
                        q_next  = '0;
                    end
                end
                else
                begin
                    major_span_next  = span_y_reg;
                    minor_span_next  = span_x_reg;
                    minor_start_next = line_reg.x_start;
                    minor_neg_next   = neg_x_reg;
                    dn_next          = neg_y_reg;
                    if (neg_y_reg)
                    begin
                        t_next  = line_reg.y_end;
                        hi_next = line_reg.y_start;
                        q_next  = span_x_reg;
                    end
                    else
                    begin
                        t_next  = line_reg.y_start;
                        hi_next = line_reg.y_end;
                        q_next  = '0;
                    end
                end
                state_next = S_RUN;
            end
            S_RUN:
            begin
                alu_op = dn_reg ? OP_STEP_DN : OP_STEP_UP;
                alu_a  = r_reg;
                alu_b  = minor_span_reg;
                alu_c  = major_span_reg;
                if (pix_take)
                begin
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        t_next = t_reg + 1'b1;
                        r_next = alu_res;
                        if (dn_reg)
                        begin
                            q_next = q_reg - COORD_W'(alu_flag);
                        end
                        else
                        begin
                            q_next = q_reg + COORD_W'(alu_flag);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            line_reg        <= '0;
            span_x_reg      <= '0;
            span_y_reg      <= '0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            x_major_reg     <= 1'b0;
            dn_reg          <= 1'b0;
            t_reg           <= '0;
            hi_reg          <= '0;
            q_reg           <= '0;
            r_reg           <= '0;
            major_span_reg  <= '0;
            minor_span_reg  <= '0;
            minor_start_reg <= '0;
            minor_neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_reg        <= line_next;
            span_x_reg      <= span_x_next;
            span_y_reg      <= span_y_next;
            neg_x_reg       <= neg_x_next;
            neg_y_reg       <= neg_y_next;
            x_major_reg     <= x_major_next;
            dn_reg          <= dn_next;
            t_reg           <= t_next;
            hi_reg          <= hi_next;
            q_reg           <= q_next;
            r_reg           <= r_next;
            major_span_reg  <= major_span_next;
            minor_span_reg  <= minor_span_next;
            minor_start_reg <= minor_start_next;
            minor_neg_reg   <= minor_neg_next;
        end
    end

    // Remainder stays below the major span while walking
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> ((r_reg < major_span_reg) || (r_reg == '0)))
        else $error("remainder out of range");

    // Minor offset never exceeds the minor span
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (q_reg <= minor_span_reg))
        else $error("minor offset beyond span");

    // Handing over the last pixel ends the line
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_take && pix.last) |=> (state_reg == S_IDLE))
        else $error("walk continued past last pixel");

    // A request starts the span set-up
    a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (idle && start) |=> (state_reg == S_DX))
        else $error("request not taken into set-up");

endmodule

[rtl/line_pixel_rasterizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_top
// Line rasterizer: one line request in, one pixel write per major-axis step.
// ----------------------------------------------------------------------------
// A request carries two endpoints and a colour. The block walks the major axis
// (x on ties) from the smaller coordinate to the larger and emits one pixel
// write per step: index x + FRAME_WIDTH*y (12 bits, no clipping), the colour,
// and last_pixel on the final write. A zero-length line gives a single pixel.
// Sequence: a request is taken while idle, followed by the set-up states on the
// shared add/compare unit (x span, y span, span compare), then one pixel per
// cycle while the output side does not stall, N+1 pixels for a major span of
// N; the shared unit, giving one remainder step per cycle, sets the pixel rate.
// in_ready is high again once the last pixel sits in the output register, so
// the next request may be taken while that pixel still waits to be read.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_top #(
    parameter int FRAME_WIDTH = lpr_pkg::FRAME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lpr_pkg::COORD_W-1:0]   x_start,
    input  logic [lpr_pkg::COORD_W-1:0]   y_start,
    input  logic [lpr_pkg::COORD_W-1:0]   x_end,
    input  logic [lpr_pkg::COORD_W-1:0]   y_end,
    input  logic [lpr_pkg::COLOR_W-1:0]   line_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lpr_pkg::INDEX_W-1:0]   pixel_index,
    output logic [lpr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                          last_pixel
);
    import lpr_pkg::*;

    // Row stride of the linear index, kept to the index width
    localparam logic [INDEX_W-1:0] ROW_STRIDE = INDEX_W'(FRAME_WIDTH);

    logic                 start;
    logic                 idle;
    line_t                line;
    logic                 pix_valid;
    pix_t                 pix;
    logic                 pix_take;
    logic [INDEX_W-1:0]   pix_index;

    logic [COLOR_W-1:0]   color_reg, color_next;
    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;
    logic                 last_reg, last_next;

    assign in_ready     = idle;
    assign start        = in_valid && in_ready;
    assign line.x_start = x_start;
    assign line.y_start = y_start;
    assign line.x_end   = x_end;
    assign line.y_end   = y_end;

    lpr_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .line      (line),
        .idle      (idle),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_take  (pix_take)
    );

    // Advance the walk whenever the output register is free or being drained
    assign pix_take  = !out_valid_reg || out_ready;
    assign pix_index = INDEX_W'(pix.x) + ROW_STRIDE * INDEX_W'(pix.y);

    always_comb
    begin
        color_next     = color_reg;
        out_valid_next = out_valid_reg;
        index_next     = index_reg;
        out_color_next = out_color_reg;
        last_next      = last_reg;
        // Hold the colour for the whole walk
        if (start)
        begin
            color_next = line_color;
        end
        if (pix_valid && pix_take)
        begin
            out_valid_next = 1'b1;
            index_next     = pix_index;
            out_color_next = color_reg;
            last_next      = pix.last;
        end
        else if (out_ready)
        begin
            // Drop the pixel once it has been taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        index_reg     <= index_next;
        out_color_reg <= out_color_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = index_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel  = last_reg;

endmodule
